// ===== hw/rtl/sbpg_pkg.sv =====
package sbpg_pkg;

  localparam int FRAME_BITS      = 12;
  localparam int BAR_CNT_BITS    = 7;
  localparam int GAP_BITS        = 8;
  localparam int INDEX_BITS      = 6;
  localparam int LEVEL_BITS      = 17;
  localparam int COLOR_BITS      = 7;
  localparam int PITCH_BITS      = 13;
  localparam int MAX_COORD_BITS  = 16;
  localparam int RECIP_BITS      = MAX_COORD_BITS + 1;
  localparam int DCOLOR_BITS     = 23;
  localparam int DIV_BITS        = 24;
  localparam int A125_BITS       = 24;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 12;

  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = 17'h10000;
  localparam logic [A125_BITS-1:0]  COLOR_SPAN = 24'd125;
  localparam logic [DIV_BITS-1:0]   DCOLOR_DIVIDEND = 24'd125 << 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BAR_COUNT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BAR_GAP      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd3;

  localparam logic [BAR_CNT_BITS-1:0] RST_BAR_COUNT    = 7'd25;
  localparam logic [GAP_BITS-1:0]     RST_BAR_GAP      = 8'd0;
  localparam logic [FRAME_BITS-1:0]   RST_FRAME_WIDTH  = 12'd640;
  localparam logic [FRAME_BITS-1:0]   RST_FRAME_HEIGHT = 12'd480;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Per-configuration bar layout; the user must keep it constant while pixels are in flight (not enforced here)
  typedef struct packed {
    logic                    ok;
    logic [BAR_CNT_BITS-1:0] bars;
    logic [FRAME_BITS-1:0]   bw;
    logic [FRAME_BITS-1:0]   x0;
    logic [PITCH_BITS-1:0]   pitch;
    logic [RECIP_BITS-1:0]   recip;
    logic [FRAME_BITS-1:0]   height;
    logic [DCOLOR_BITS-1:0]  dcolor;
  } layout_t;

endpackage

// ===== hw/rtl/sbpg_layout.sv =====
module sbpg_layout import sbpg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output layout_t                  lay,
  output logic                     ready
);

  localparam int CW = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;
  localparam int CNT_BITS = $clog2(DIV_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

  typedef enum logic [2:0] {
    ST_START, ST_BW, ST_PITCH, ST_RECIP, ST_DCOLOR, ST_READY
  } state_t;

  state_t                  state;
  logic [BAR_CNT_BITS-1:0] bar_count;
  logic [GAP_BITS-1:0]     bar_gap;
  logic [FRAME_BITS-1:0]   frame_width;
  logic [FRAME_BITS-1:0]   frame_height;

  logic [DIV_BITS-1:0]     div_q;
  logic [PITCH_BITS:0]     div_r;
  logic [PITCH_BITS-1:0]   div_d;
  logic [CNT_BITS-1:0]     cnt;

  logic [14:0]             spaces;
  logic [15:0]             rem_w;
  logic                    ok_calc;
  logic [PITCH_BITS:0]     r_sh;
  logic                    r_ge;
  logic [PITCH_BITS:0]     r_next;
  logic [DIV_BITS-1:0]     q_next;
  logic [PITCH_BITS-1:0]   pitch_calc;

  always_comb begin
    spaces  = 15'(bar_gap) * 15'(bar_count - 7'd1);
    rem_w   = 16'(frame_width) - 16'(spaces);
    ok_calc = (bar_count != '0) && (frame_height != '0) && !rem_w[15] &&
              (rem_w >= 16'(bar_count));
    // one restoring division step
    r_sh    = {div_r[PITCH_BITS-1:0], div_q[DIV_BITS-1]};
    r_ge    = (r_sh >= {1'b0, div_d});
    r_next  = r_ge ? (r_sh - {1'b0, div_d}) : r_sh;
    q_next  = {div_q[DIV_BITS-2:0], r_ge};
    pitch_calc = PITCH_BITS'(lay.bw) + PITCH_BITS'(bar_gap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      bar_count    <= RST_BAR_COUNT;
      bar_gap      <= RST_BAR_GAP;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      lay.ok       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BAR_COUNT:    bar_count    <= cfg_data[BAR_CNT_BITS-1:0];
        CFG_BAR_GAP:      bar_gap      <= cfg_data[GAP_BITS-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_BITS-1:0];
        default: ;
      endcase
      state <= ST_START;
    end else begin
      case (state)
        ST_START: begin
          lay.ok     <= ok_calc;
          lay.bars   <= bar_count;
          lay.height <= frame_height;
          div_q      <= DIV_BITS'(rem_w[FRAME_BITS-1:0]);
          div_d      <= PITCH_BITS'(bar_count);
          div_r      <= '0;
          cnt        <= '0;
          state      <= ST_BW;
        end
        ST_BW: begin
          div_q <= q_next;
          div_r <= r_next;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            lay.bw <= q_next[FRAME_BITS-1:0];
            lay.x0 <= FRAME_BITS'(r_next[PITCH_BITS-1:1]);
            state  <= ST_PITCH;
          end
        end
        ST_PITCH: begin
          lay.pitch <= pitch_calc;
          div_q     <= DIV_BITS'(1) << CW;
          div_d     <= pitch_calc;
          div_r     <= '0;
          cnt       <= '0;
          state     <= ST_RECIP;
        end
        ST_RECIP: begin
          if (cnt == CNT_LAST) begin
            lay.recip <= q_next[RECIP_BITS-1:0];
            div_q     <= DCOLOR_DIVIDEND;
            div_d     <= PITCH_BITS'(frame_height);
            div_r     <= '0;
            cnt       <= '0;
            state     <= ST_DCOLOR;
          end else begin
            div_q <= q_next;
            div_r <= r_next;
            cnt   <= cnt + 1'b1;
          end
        end
        ST_DCOLOR: begin
          div_q <= q_next;
          div_r <= r_next;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            lay.dcolor <= q_next[DCOLOR_BITS-1:0];
            state      <= ST_READY;
          end
        end
        ST_READY: ;
        default: state <= ST_START;
      endcase
    end
  end

  assign ready = (state == ST_READY);

endmodule

// ===== hw/rtl/sbpg_locate.sv =====
module sbpg_locate import sbpg_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int MAX_BARS   = 64,
  parameter int AW         = 6
) (
  input  logic                     clk,
  input  logic                     rst,
  input  layout_t                  lay,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic [INDEX_BITS-1:0]    bar_index,
  input  logic [LEVEL_BITS-1:0]    level,
  input  logic [COORD_BITS-1:0]    pixel_x,
  input  logic [COORD_BITS-1:0]    pixel_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_mode,
  output logic [INDEX_BITS-1:0]    out_idx,
  output logic [LEVEL_BITS-1:0]    out_lvl,
  output logic [FRAME_BITS-1:0]    out_py,
  output logic                     out_hit,
  output logic [AW-1:0]            out_bar
);

  localparam int CW = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;
  localparam int QW = CW + RECIP_BITS;
  localparam int PW = CW + PITCH_BITS;
  localparam logic [CW:0] MAX_K = (CW+1)'(MAX_BARS);

  // stage registers
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;
  logic m1, m2, m3, m4;
  logic [INDEX_BITS-1:0] i1, i2, i3, i4;
  logic [LEVEL_BITS-1:0] l1, l2, l3, l4;
  logic [CW-1:0] py1, py2, py3, py4;
  logic [CW-1:0] off1, off2, off3;
  logic b1, b2, b3, b4;
  logic [CW-1:0] kq2, kq3, kq4;
  logic [CW-1:0] prod3;
  logic [CW-1:0] r4;

  logic [CW-1:0] px_e, x0_e;
  logic [QW-1:0] q_prod;
  logic [PW-1:0] p_prod;
  logic [PW-1:0] r_e, pitch_e, bw_e;
  logic          r_ge;
  logic [CW:0]   k;
  logic [PW-1:0] r_fix;
  logic          hit;

  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    px_e    = CW'(pixel_x);
    x0_e    = CW'(lay.x0);
    q_prod  = QW'(off1) * QW'(lay.recip);
    p_prod  = PW'(kq2) * PW'(lay.pitch);
    r_e     = PW'(r4);
    pitch_e = PW'(lay.pitch);
    bw_e    = PW'(lay.bw);
    // estimated quotient is exact or one short
    r_ge    = (r_e >= pitch_e);
    k       = (CW+1)'(kq4) + (CW+1)'(r_ge);
    r_fix   = r_ge ? (r_e - pitch_e) : r_e;
    hit     = lay.ok && !b4 && (k < (CW+1)'(lay.bars)) && (k < MAX_K) &&
              (r_fix < bw_e) && (py4 < CW'(lay.height));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      m1   <= mode;
      i1   <= bar_index;
      l1   <= (level > FULL_SCALE) ? FULL_SCALE : level;
      py1  <= CW'(pixel_y);
      b1   <= (px_e < x0_e);
      off1 <= px_e - x0_e;
    end
    if (en2) begin
      m2   <= m1;
      i2   <= i1;
      l2   <= l1;
      py2  <= py1;
      b2   <= b1;
      off2 <= off1;
      kq2  <= q_prod[CW +: CW];
    end
    if (en3) begin
      m3    <= m2;
      i3    <= i2;
      l3    <= l2;
      py3   <= py2;
      b3    <= b2;
      off3  <= off2;
      kq3   <= kq2;
      prod3 <= p_prod[CW-1:0];
    end
    if (en4) begin
      m4  <= m3;
      i4  <= i3;
      l4  <= l3;
      py4 <= py3;
      b4  <= b3;
      kq4 <= kq3;
      r4  <= off3 - prod3;
    end
    if (en5) begin
      out_mode <= m4;
      out_idx  <= i4;
      out_lvl  <= l4;
      out_py   <= FRAME_BITS'(py4);
      out_hit  <= hit;
      out_bar  <= AW'(k);
    end
  end

  assign out_valid = v5;

endmodule

// ===== hw/rtl/sbpg_level_mem.sv =====
module sbpg_level_mem import sbpg_pkg::*; #(
  parameter int MAX_BARS = 64,
  parameter int AW       = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [INDEX_BITS-1:0] in_idx,
  input  logic [LEVEL_BITS-1:0] in_lvl,
  input  logic [FRAME_BITS-1:0] in_py,
  input  logic                  in_hit,
  input  logic [AW-1:0]         in_bar,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAME_BITS-1:0] out_py,
  output logic                  out_hit,
  output logic [LEVEL_BITS-1:0] out_level
);

  logic [LEVEL_BITS-1:0] mem [MAX_BARS];
  logic [MAX_BARS-1:0]   written;

  logic                  vm;
  logic                  mode_m;
  logic [LEVEL_BITS-1:0] rd_data;
  logic                  rd_written;
  logic                  en;
  logic                  store_ok;
  logic [AW-1:0]         waddr;

  assign out_valid = vm && (mode_m == MODE_PIXEL);
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign store_ok  = in_valid && (in_mode == MODE_STORE) && (32'(in_idx) < MAX_BARS);
  assign waddr     = AW'(in_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm      <= 1'b0;
      written <= '0;
    end else if (en) begin
      vm <= in_valid;
      if (store_ok) written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_m <= in_mode;
      out_py <= in_py;
      out_hit <= in_hit;
      if (store_ok) begin
        mem[waddr] <= in_lvl;
      end else begin
        rd_data    <= mem[in_bar];
        rd_written <= written[in_bar];
      end
    end
  end

  // entry never stored reads as zero amplitude
  assign out_level = rd_written ? rd_data : '0;

endmodule

// ===== hw/rtl/sbpg_shade.sv =====
module sbpg_shade import sbpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  layout_t               lay,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FRAME_BITS-1:0] in_py,
  input  logic                  in_hit,
  input  logic [LEVEL_BITS-1:0] in_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_BITS-1:0] color_index,
  output logic                  inside_bar
);

  localparam int TW = LEVEL_BITS + FRAME_BITS;
  localparam int DW = FRAME_BITS + DCOLOR_BITS;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic [FRAME_BITS-1:0] py1;
  logic                  hit1, lit2, lit3;
  logic [FRAME_BITS-1:0] top1;
  logic [A125_BITS-1:0]  a125_1, base2, base3;
  logic [FRAME_BITS-1:0] dy2;
  logic [DW-1:0]         dprod3;

  logic [TW-1:0]         top_prod;
  logic [DW-1:0]         dprod;
  logic [DW-1:0]         diff;
  logic                  neg;
  logic [COLOR_BITS-1:0] color;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v4;

  always_comb begin
    top_prod = TW'(FULL_SCALE - in_level) * TW'(lay.height);
    dprod    = DW'(dy2) * DW'(lay.dcolor);
    neg      = (dprod3 > DW'(base3));
    diff     = DW'(base3) - dprod3;
    color    = diff[16 +: COLOR_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      py1    <= in_py;
      hit1   <= in_hit;
      top1   <= top_prod[16 +: FRAME_BITS];
      a125_1 <= A125_BITS'(in_level) * COLOR_SPAN;
    end
    if (en2) begin
      lit2  <= hit1 && (top1 < lay.height) && (py1 >= top1);
      dy2   <= py1 - top1;
      base2 <= A125_BITS'(FULL_SCALE) + a125_1;
    end
    if (en3) begin
      lit3   <= lit2;
      base3  <= base2;
      dprod3 <= dprod;
    end
    if (en4) begin
      color_index <= (lit3 && !neg) ? color : '0;
      inside_bar  <= lit3 && !neg && (color != '0);
    end
  end

endmodule

// ===== hw/rtl/spectrum_bar_pixel_generator_unit.sv =====
// Bar-graph pixel generator for a spectrum display.
//
// Input channel (in_valid/in_ready): mode 0 stores bar_index's amplitude
// (level, unsigned 1.16, clamped to 1.0); mode 1 asks for the palette
// index of pixel (pixel_x, pixel_y). Only pixel transactions produce an
// output transaction (out_valid/out_ready: color_index, inside_bar).
// Configuration: cfg_write with cfg_index 0..3 writes bar_count, bar_gap,
// frame_width, frame_height; write only while no transaction is in flight.
//
// Throughput is one transaction per cycle while no stall or layout recompute
// holds in_ready low. A pixel passes through 5 stages that locate the bar
// column (reciprocal multiply plus one correction step), then 1 stage that
// reads the level memory, then 4 stages that compute bar top and color.
// After reset and after every configuration write, a shared serial divider
// recomputes the bar layout; in_ready stays low meanwhile.
// Reset clears the level table (all bars read zero) and all valid bits.
// When the receiver holds out_ready low, each stage keeps its item and
// empty stages still fill, so the input keeps taking transactions until
// the whole pipeline is full; nothing is dropped or repeated.
module spectrum_bar_pixel_generator_unit import sbpg_pkg::*; #(
  parameter int MAX_BARS   = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic [INDEX_BITS-1:0]    bar_index,
  input  logic [LEVEL_BITS-1:0]    level,
  input  logic [COORD_BITS-1:0]    pixel_x,
  input  logic [COORD_BITS-1:0]    pixel_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COLOR_BITS-1:0]    color_index,
  output logic                     inside_bar
);

  localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

  layout_t lay;
  logic    lay_ready;
  logic    open_gate;

  logic                  loc_in_ready;
  logic                  loc_valid, loc_ready;
  logic                  loc_mode, loc_hit;
  logic [INDEX_BITS-1:0] loc_idx;
  logic [LEVEL_BITS-1:0] loc_lvl;
  logic [FRAME_BITS-1:0] loc_py;
  logic [AW-1:0]         loc_bar;

  logic                  mem_valid, mem_ready, mem_hit;
  logic [FRAME_BITS-1:0] mem_py;
  logic [LEVEL_BITS-1:0] mem_level;

  // hold off transactions while the layout is being recomputed
  assign open_gate = lay_ready && !cfg_write;
  assign in_ready  = loc_in_ready && open_gate;

  sbpg_layout #(
    .COORD_BITS(COORD_BITS)
  ) u_layout (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lay       (lay),
    .ready     (lay_ready)
  );

  // column to bar number and in-bar test
  sbpg_locate #(
    .COORD_BITS(COORD_BITS),
    .MAX_BARS  (MAX_BARS),
    .AW        (AW)
  ) u_locate (
    .clk       (clk),
    .rst       (rst),
    .lay       (lay),
    .in_valid  (in_valid && open_gate),
    .in_ready  (loc_in_ready),
    .mode      (mode),
    .bar_index (bar_index),
    .level     (level),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_valid (loc_valid),
    .out_ready (loc_ready),
    .out_mode  (loc_mode),
    .out_idx   (loc_idx),
    .out_lvl   (loc_lvl),
    .out_py    (loc_py),
    .out_hit   (loc_hit),
    .out_bar   (loc_bar)
  );

  // stores write and pixels read at the same stage, so order is kept;
  // store transactions end here
  sbpg_level_mem #(
    .MAX_BARS(MAX_BARS),
    .AW      (AW)
  ) u_level_mem (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (loc_valid),
    .in_ready  (loc_ready),
    .in_mode   (loc_mode),
    .in_idx    (loc_idx),
    .in_lvl    (loc_lvl),
    .in_py     (loc_py),
    .in_hit    (loc_hit),
    .in_bar    (loc_bar),
    .out_valid (mem_valid),
    .out_ready (mem_ready),
    .out_py    (mem_py),
    .out_hit   (mem_hit),
    .out_level (mem_level)
  );

  // bar top and color falloff, output register at the end
  sbpg_shade u_shade (
    .clk         (clk),
    .rst         (rst),
    .lay         (lay),
    .in_valid    (mem_valid),
    .in_ready    (mem_ready),
    .in_py       (mem_py),
    .in_hit      (mem_hit),
    .in_level    (mem_level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color_index (color_index),
    .inside_bar  (inside_bar)
  );

endmodule

// ===== hw/rtl/sbpg_checker.sv =====
module sbpg_checker import sbpg_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_write,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [COLOR_BITS-1:0]    color_index,
  input logic                     inside_bar
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(color_index) && $stable(inside_bar))
    else $error("output changed while stalled");

  // lit flag matches a nonzero palette index
  a_lit_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inside_bar == (color_index != '0)))
    else $error("inside_bar disagrees with color_index");

  // palette index never exceeds the top of the color ramp
  a_color_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (color_index != 7'd127))
    else $error("color_index out of range");

  // layout recompute blocks input after a configuration write
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !in_ready)
    else $error("input taken during layout recompute");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind spectrum_bar_pixel_generator_unit sbpg_checker u_sbpg_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_write   (cfg_write),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .color_index (color_index),
  .inside_bar  (inside_bar)
);
